FILE: rtl/core/cqt_pkg.sv
// Shared types and constants for the CSV quoted field tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package cqt_pkg;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef enum logic [1:0] {
    EV_CHAR  = 2'd0,
    EV_FIELD = 2'd1,
    EV_ROW   = 2'd2
  } event_kind_e;

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  ch;
  } event_t;

endpackage
`default_nettype wire

FILE: rtl/core/cqt_front.sv
// Front end: accept text words, track quote state, classify into events.
`timescale 1ns / 1ps
`default_nettype none
module cqt_front import cqt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       end_of_text_i,
  input  wire logic       q_ready_i,
  output logic            q_push_o,
  output event_t          q_data_o
);

  typedef enum logic [1:0] {
    MODE_OUT    = 2'd0,
    MODE_IN     = 2'd1,
    MODE_CLOSED = 2'd2
  } mode_e;

  mode_e  mode_q, mode_d;
  logic   row_open_q, row_open_d;
  logic   emit;
  event_t ev;
  logic   accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign q_push_o   = accept && emit;
  assign q_data_o   = ev;

  // Classify the word against the current quote mode
  always_comb begin
    logic outside;
    outside    = 1'b0;
    mode_d     = mode_q;
    row_open_d = row_open_q;
    emit       = 1'b0;
    ev.kind    = EV_CHAR;
    ev.ch      = 8'h00;
    if (end_of_text_i) begin
      emit       = row_open_q;
      ev.kind    = EV_ROW;
      mode_d     = MODE_OUT;
      row_open_d = 1'b0;
    end else begin
      row_open_d = 1'b1;
      case (mode_q)
        MODE_IN: begin
          if (text_byte_i == ChQuote) begin
            mode_d = MODE_CLOSED;
          end else begin
            emit  = 1'b1;
            ev.ch = text_byte_i;
          end
        end
        MODE_CLOSED: begin
          if (text_byte_i == ChQuote) begin
            mode_d = MODE_IN;
            emit   = 1'b1;
            ev.ch  = ChQuote;
          end else begin
            outside = 1'b1;
          end
        end
        default: outside = 1'b1;
      endcase
      if (outside) begin
        mode_d = MODE_OUT;
        if (text_byte_i == ChQuote) begin
          mode_d = MODE_IN;
        end else if (text_byte_i == ChComma) begin
          emit    = 1'b1;
          ev.kind = EV_FIELD;
        end else if (text_byte_i == ChLf) begin
          emit       = 1'b1;
          ev.kind    = EV_ROW;
          row_open_d = 1'b0;
        end else if (text_byte_i != ChCr) begin
          emit  = 1'b1;
          ev.ch = text_byte_i;
        end
      end
    end
  end

  // Advance state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_OUT;
      row_open_q <= 1'b0;
    end else if (accept) begin
      mode_q     <= mode_d;
      row_open_q <= row_open_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/cqt_queue.sv
// Two-entry event queue between front end and output stage.
`timescale 1ns / 1ps
`default_nettype none
module cqt_queue import cqt_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire event_t push_data_i,
  output logic        ready_o,
  output logic        valid_o,
  input  wire logic   pop_i,
  output event_t      pop_data_o
);

  event_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_pop;

  assign ready_o    = (count_q != 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/cqt_back.sv
// Back end: output register that presents events to the receiver.
`timescale 1ns / 1ps
`default_nettype none
module cqt_back import cqt_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   q_valid_i,
  input  wire event_t q_data_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [1:0]  event_kind_o,
  output logic [7:0]  char_value_o
);

  logic   valid_q;
  event_t data_q;

  assign q_pop_o      = q_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o  = valid_q;
  assign event_kind_o = data_q.kind;
  assign char_value_o = data_q.ch;

  // Load a new word when the register is empty or being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= q_valid_i;
    end
  end

  // Hold payload until taken
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= q_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/csv_quoted_field_tokenizer.sv
// Top level of the CSV quoted field tokenizer.
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one text word per cycle:
//   text_byte_i plus end_of_text_i, which flushes an open row and returns
//   the quote tracker to its start state.
//   Output channel (out_valid_o/out_ready_i) gives zero or one event per
//   input word: event_kind_o 0 = character (char_value_o), 1 = end of
//   field, 2 = end of row. char_value_o is zero for kinds 1 and 2.
//   Path: the front end classifies a word in its accept cycle; the event
//   is written into the two-entry queue, then into the output register,
//   and a receiver stall can hold it in either.
//   Throughput: one word per cycle while in_ready_o is high; quote state
//   updates on each accepted word, so back-to-back words need no gap.
//   Reset: asynchronous, active low; clears quote mode, row tracking,
//   queue and output register. No start-up pass is needed.
//   Receiver stall: the output register holds, the queue absorbs up to
//   two more events, then in_ready_o drops until the receiver drains.
`timescale 1ns / 1ps
`default_nettype none
module csv_quoted_field_tokenizer import cqt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       end_of_text_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      event_kind_o,
  output logic [7:0]      char_value_o
);

  logic   q_ready, q_push, q_valid, q_pop;
  event_t q_wdata, q_rdata;

  cqt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .q_ready_i    (q_ready),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  cqt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .pop_data_o (q_rdata)
  );

  cqt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_kind_o(event_kind_o),
    .char_value_o(char_value_o)
  );

`ifndef ASSERT_OFF
  // Only defined event kinds leave the block
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_kind_o != 2'd3))
    else $error("illegal event kind on output");

  // Field and row ends carry a zero character
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_kind_o != EV_CHAR)) |-> (char_value_o == 8'h00))
    else $error("nonzero character on end event");

  // A new output word must have come from the queue
  a_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(q_valid))
    else $error("output valid without queued word");

  // Front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> q_ready)
    else $error("push into full queue");
`endif

endmodule
`default_nettype wire
